[design/abt_pkg.sv]
// ----------------------------------------------------------------------------
// Address backpatch table package
// Sizes, codes and the entry record shared by the backpatch table design.
// ----------------------------------------------------------------------------
package abt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_PENDING   = 16;
  localparam int SLOT_BITS     = 16;

  localparam int SLOT_W   = (SLOT_BITS < 16) ? SLOT_BITS : 16;
  localparam int ENTRY_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W   = ENTRY_W + 1;
  localparam int CNT_W    = $clog2(MAX_PENDING + 1);
  localparam int PADDR_W  = $clog2(TABLE_ENTRIES * MAX_PENDING);
  localparam int PDEPTH   = TABLE_ENTRIES * MAX_PENDING;

  localparam logic OP_DEFINE    = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [1:0] ST_PATCH        = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL   = 2'd1;
  localparam logic [1:0] ST_PENDING_FULL = 2'd2;

  typedef struct packed {
    logic              known;
    logic [CNT_W-1:0]  count;
    logic [31:0]       target;
  } rec_t;

endpackage

[design/abt_if.sv]
// ----------------------------------------------------------------------------
// Address backpatch table channels
// Input item channel and result channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface abt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] orig_addr;
  logic [31:0] reloc_addr;
  logic [15:0] ref_slot;

  modport source (output valid, operation, orig_addr, reloc_addr, ref_slot, input ready);
  modport sink (input valid, operation, orig_addr, reloc_addr, ref_slot, output ready);
endinterface

interface abt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] patch_slot;
  logic [31:0] patch_addend;
  logic        last;

  modport source (output valid, status, patch_slot, patch_addend, last, input ready);
  modport sink (input valid, status, patch_slot, patch_addend, last, output ready);
endinterface

[design/address_backpatch_table_core.sv]
// ----------------------------------------------------------------------------
// Address backpatch table core
// Maps old addresses to new ones and releases queued fixup slots on define.
// ----------------------------------------------------------------------------
// An item is accepted in IDLE, the allocated entries of the key memory are
// searched in turn in SCAN, and the record of a matching entry is examined
// in ENTRY; a new address goes to ALLOC instead, and a define releases its
// queued slots as patch beats in DRAIN. A new item is accepted only in IDLE,
// after the last one is done, and a result beat waits while the one before it is not taken.
// Reset clears the fill count, the state and the result valid flag; the
// memories are not cleared, since the contents of entries beyond the fill
// count are never used.
module address_backpatch_table_core (
  input logic clk,
  input logic rst,
  abt_in_if.sink    items,
  abt_out_if.source results
);
  import abt_pkg::*;

  typedef enum logic [2:0] {IDLE, SCAN, ALLOC, ENTRY, DRAIN} state_t;

  state_t              state;
  logic                op;
  logic [31:0]         key;
  logic [31:0]         naddr;
  logic [SLOT_W-1:0]   slot;
  logic [ENTRY_W-1:0]  idx;
  logic [ENTRY_W-1:0]  e;
  logic [FILL_W-1:0]   fill;
  logic [CNT_W-1:0]    j;
  logic [CNT_W-1:0]    cnt;
  logic                ovalid;
  logic [1:0]          ostatus;
  logic [15:0]         oslot;
  logic [31:0]         oaddend;
  logic                olast;

  logic                out_free;
  logic                out_load;
  logic                key_match;
  logic                scan_last;
  logic                full;
  logic                drain_last;
  logic [PADDR_W-1:0]  ebase;
  logic [PADDR_W-1:0]  nbase;

  logic                key_we;
  logic [ENTRY_W-1:0]  key_waddr;
  logic [ENTRY_W-1:0]  key_raddr;
  logic [31:0]         key_rdata;
  logic                rec_we;
  logic [ENTRY_W-1:0]  rec_waddr;
  rec_t                rec_wdata;
  logic [ENTRY_W-1:0]  rec_raddr;
  rec_t                rec_rdata;
  logic                pend_we;
  logic [PADDR_W-1:0]  pend_waddr;
  logic [SLOT_W-1:0]   pend_wdata;
  logic [PADDR_W-1:0]  pend_raddr;
  logic [SLOT_W-1:0]   pend_rdata;

  assign items.ready          = (state == IDLE);
  assign results.valid        = ovalid;
  assign results.status       = ostatus;
  assign results.patch_slot   = oslot;
  assign results.patch_addend = oaddend;
  assign results.last         = olast;

  assign out_free   = !ovalid || results.ready;
  assign out_load   = out_free && ((state == ALLOC && full) ||
                      (state == ENTRY && op == OP_TRANSLATE &&
                       (rec_rdata.known || rec_rdata.count >= CNT_W'(MAX_PENDING))) ||
                      (state == DRAIN));
  assign key_match  = (key_rdata == key);
  assign scan_last  = (FILL_W'(idx) + FILL_W'(1)) == fill;
  assign full       = (fill == FILL_W'(TABLE_ENTRIES));
  assign drain_last = (j + CNT_W'(1)) == cnt;
  assign ebase      = PADDR_W'(e) * PADDR_W'(MAX_PENDING);
  assign nbase      = PADDR_W'(fill[ENTRY_W-1:0]) * PADDR_W'(MAX_PENDING);

  always_comb begin
    key_we     = 1'b0;
    key_waddr  = fill[ENTRY_W-1:0];
    key_raddr  = '0;
    rec_we     = 1'b0;
    rec_waddr  = e;
    rec_wdata  = '{known: 1'b1, count: '0, target: naddr};
    rec_raddr  = (state == SCAN) ? idx : e;
    pend_we    = 1'b0;
    pend_waddr = nbase;
    pend_wdata = slot;
    pend_raddr = ebase;
    case (state)
      SCAN: begin
        key_raddr = idx + ENTRY_W'(1);
      end
      ALLOC: begin
        if (!full) begin
          key_we    = 1'b1;
          rec_we    = 1'b1;
          rec_waddr = fill[ENTRY_W-1:0];
          if (op == OP_TRANSLATE) begin
            rec_wdata = '{known: 1'b0, count: CNT_W'(1), target: naddr};
            pend_we   = 1'b1;
          end
        end
      end
      ENTRY: begin
        if (op == OP_DEFINE) begin
          rec_we = 1'b1;
        end else if (!rec_rdata.known && rec_rdata.count < CNT_W'(MAX_PENDING)) begin
          rec_we     = 1'b1;
          rec_wdata  = '{known: 1'b0, count: rec_rdata.count + CNT_W'(1),
                         target: rec_rdata.target};
          pend_we    = 1'b1;
          pend_waddr = ebase + PADDR_W'(rec_rdata.count);
        end
      end
      DRAIN: begin
        pend_raddr = ebase + PADDR_W'(j) + PADDR_W'(out_free);
      end
      default: begin
      end
    endcase
  end

  abt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  abt_ram #(.WIDTH($bits(rec_t)), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  abt_ram #(.WIDTH(SLOT_W), .DEPTH(PDEPTH)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      fill   <= '0;
      ovalid <= 1'b0;
    end else begin
      if (out_free) begin
        ovalid <= out_load;
      end
      case (state)
        IDLE: begin
          if (items.valid) begin
            op    <= items.operation;
            key   <= items.orig_addr;
            naddr <= items.reloc_addr;
            slot  <= items.ref_slot[SLOT_W-1:0];
            idx   <= '0;
            state <= (fill == '0) ? ALLOC : SCAN;
          end
        end
        SCAN: begin
          if (key_match) begin
            e     <= idx;
            state <= ENTRY;
          end else if (scan_last) begin
            state <= ALLOC;
          end else begin
            idx <= idx + ENTRY_W'(1);
          end
        end
        ALLOC: begin
          if (!full) begin
            fill  <= fill + FILL_W'(1);
            state <= IDLE;
          end else if (out_free) begin
            ostatus <= ST_TABLE_FULL;
            oslot   <= '0;
            oaddend <= '0;
            olast   <= 1'b1;
            state   <= IDLE;
          end
        end
        ENTRY: begin
          if (op == OP_DEFINE) begin
            cnt   <= rec_rdata.count;
            j     <= '0;
            state <= (rec_rdata.count == '0) ? IDLE : DRAIN;
          end else if (rec_rdata.known) begin
            if (out_free) begin
              ostatus <= ST_PATCH;
              oslot   <= 16'(slot);
              oaddend <= rec_rdata.target;
              olast   <= 1'b1;
              state   <= IDLE;
            end
          end else if (rec_rdata.count >= CNT_W'(MAX_PENDING)) begin
            if (out_free) begin
              ostatus <= ST_PENDING_FULL;
              oslot   <= '0;
              oaddend <= '0;
              olast   <= 1'b1;
              state   <= IDLE;
            end
          end else begin
            state <= IDLE;
          end
        end
        DRAIN: begin
          if (out_free) begin
            ostatus <= ST_PATCH;
            oslot   <= 16'(pend_rdata);
            oaddend <= naddr;
            olast   <= drain_last;
            j       <= j + CNT_W'(1);
            if (drain_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> FILL_W'(idx) < fill)
    else $error("key search beyond allocated entries");

  a_drain_range: assert property (@(posedge clk) disable iff (rst)
    state == DRAIN |-> j < cnt)
    else $error("release walk beyond queued slots");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (state == DRAIN && out_free && drain_last) |=> (state == IDLE && ovalid && olast))
    else $error("final released beat not marked last");
endmodule

[design/abt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module abt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sim/tb_abt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backpatch table testbench types
// Item and result records used by the stimulus, driver and monitor.
// ----------------------------------------------------------------------------
package tb_abt_pkg;

  typedef struct {
    logic        operation;
    logic [31:0] orig_addr;
    logic [31:0] reloc_addr;
    logic [15:0] ref_slot;
  } item_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] patch_slot;
    logic [31:0] patch_addend;
    logic        last;
  } patch_t;

endpackage

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backpatch table core testbench
// Drives define and translate beats through random bursts and gaps, keeps its
// own copy of the address table and its fixup queues, and compares every
// result beat with the predicted patch or error in order.
// ----------------------------------------------------------------------------
module tb_top;
  import abt_pkg::*;
  import tb_abt_pkg::*;

  localparam int LIMIT    = 2000000;
  localparam int HOLD_AT  = 40;
  localparam int HOLD_LEN = 300;

  logic clk;
  logic rst;
  abt_in_if  items ();
  abt_out_if results ();

  address_backpatch_table_core dut (
    .clk(clk), .rst(rst), .items(items.sink), .results(results.source)
  );

  item_t  pending_items[$];
  patch_t expected_patches[$];
  int     errors = 0;
  int     cycles = 0;
  int     gap_left;
  int     burst_left;
  int     hold_left;
  bit     stim_done;

  // Predicted table state.
  bit          tbl_valid[TABLE_ENTRIES];
  bit          tbl_known[TABLE_ENTRIES];
  logic [31:0] tbl_key[TABLE_ENTRIES];
  logic [31:0] tbl_target[TABLE_ENTRIES];
  int          tbl_count[TABLE_ENTRIES];
  logic [15:0] tbl_fixups[TABLE_ENTRIES][MAX_PENDING];
  logic [31:0] used_keys[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic patch_t make_patch(logic [1:0] st, logic [15:0] s,
                                        logic [31:0] a, logic l);
    patch_t p;
    p.status = st;
    p.patch_slot = s;
    p.patch_addend = a;
    p.last = l;
    return p;
  endfunction

  task automatic resolve_item(item_t it);
    int e;
    int j;
    logic [15:0] s;
    e = -1;
    s = it.ref_slot & 16'((64'd1 << SLOT_BITS) - 1);
    for (j = 0; j < TABLE_ENTRIES; j++)
      if (e < 0 && tbl_valid[j] && tbl_key[j] == it.orig_addr) e = j;
    if (e < 0) begin
      for (j = 0; j < TABLE_ENTRIES; j++)
        if (e < 0 && !tbl_valid[j]) e = j;
      if (e < 0) begin
        expected_patches.push_back(make_patch(ST_TABLE_FULL, '0, '0, 1'b1));
        return;
      end
      tbl_valid[e] = 1;
      tbl_known[e] = 0;
      tbl_key[e] = it.orig_addr;
      tbl_count[e] = 0;
    end
    if (it.operation == OP_DEFINE) begin
      for (j = 0; j < tbl_count[e]; j++)
        expected_patches.push_back(make_patch(ST_PATCH, tbl_fixups[e][j], it.reloc_addr,
                                              j + 1 == tbl_count[e]));
      tbl_count[e] = 0;
      tbl_known[e] = 1;
      tbl_target[e] = it.reloc_addr;
    end else if (tbl_known[e]) begin
      expected_patches.push_back(make_patch(ST_PATCH, s, tbl_target[e], 1'b1));
    end else if (tbl_count[e] >= MAX_PENDING) begin
      expected_patches.push_back(make_patch(ST_PENDING_FULL, '0, '0, 1'b1));
    end else begin
      tbl_fixups[e][tbl_count[e]] = s;
      tbl_count[e]++;
    end
  endtask

  task automatic add_item(logic op, logic [31:0] a, logic [31:0] n, logic [15:0] s);
    item_t it;
    it.operation = op;
    it.orig_addr = a;
    it.reloc_addr = n;
    it.ref_slot = s;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return $urandom();
  endfunction

  initial begin
    int i;
    int k;
    int n;
    logic [31:0] key;
    stim_done = 0;
    add_item(OP_DEFINE, 32'h0, 32'h0, 16'h0);
    add_item(OP_TRANSLATE, 32'h0, 32'hFFFFFFFF, 16'hFFFF);
    add_item(OP_DEFINE, 32'h0, 32'hFFFFFFFF, 16'h0);
    add_item(OP_TRANSLATE, 32'h0, 32'h0, 16'h0);
    for (i = 0; i < 17; i++)
      add_item(OP_TRANSLATE, 32'hFFFFFFFF, 32'h0, 16'(i * 16'h0F0F));
    add_item(OP_DEFINE, 32'hFFFFFFFF, 32'hA5A5_5A5A, 16'hFFFF);
    add_item(OP_TRANSLATE, 32'h1234_5678, 32'h0, 16'h8001);
    add_item(OP_TRANSLATE, 32'h1234_5678, 32'h0, 16'h7FFE);
    add_item(OP_DEFINE, 32'h1234_5678, 32'h8000_0001, 16'h0);
    while (pending_items.size() < 330) begin
      key = pick_key();
      used_keys.push_back(key);
      n = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(12, 18);
      for (k = 0; k < n; k++)
        add_item(OP_TRANSLATE, key, $urandom(), 16'($urandom()));
      if ($urandom_range(0, 7) != 0)
        add_item(OP_DEFINE, key, $urandom(), 16'($urandom()));
      if ($urandom_range(0, 3) == 0)
        add_item(1'($urandom()), pick_key(), $urandom(), 16'($urandom()));
    end
    // Fill the table with fresh addresses so that allocation runs out.
    for (i = 0; i < 70; i++)
      add_item(1'($urandom()), $urandom(), $urandom(), 16'($urandom()));
    for (i = 0; i < 10; i++)
      add_item(OP_TRANSLATE, pick_key(), $urandom(), 16'($urandom()));
    wait (pending_items.size() == 0);
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
      items.operation <= 1'b0;
      items.orig_addr <= '0;
      items.reloc_addr <= '0;
      items.ref_slot <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (items.valid && items.ready) begin
        resolve_item(pending_items.pop_front());
      end
      if (items.valid && !items.ready) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        items.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !(items.valid && pending_items.size() == 0))
      begin
        items.valid <= 1'b1;
        items.operation <= pending_items[0].operation;
        items.orig_addr <= pending_items[0].orig_addr;
        items.reloc_addr <= pending_items[0].reloc_addr;
        items.ref_slot <= pending_items[0].ref_slot;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        items.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        results.ready <= (hold_left == 1);
      end else if (cycles == HOLD_AT) begin
        hold_left <= HOLD_LEN;
        results.ready <= 1'b0;
      end else if (cycles % 512 < 128) begin
        results.ready <= 1'b1;
      end else begin
        results.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    patch_t want;
    if (!rst && results.valid && results.ready) begin
      if (expected_patches.size() == 0) begin
        $error("unexpected result beat status=%0d slot=%h", results.status,
               results.patch_slot);
        errors++;
      end else begin
        want = expected_patches.pop_front();
        if (results.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, results.status);
          errors++;
        end
        if (results.patch_slot !== want.patch_slot) begin
          $error("patch_slot expected %h actual %h", want.patch_slot, results.patch_slot);
          errors++;
        end
        if (results.patch_addend !== want.patch_addend) begin
          $error("patch_addend expected %h actual %h", want.patch_addend,
                 results.patch_addend);
          errors++;
        end
        if (results.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, results.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b1;
    @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    @(posedge clk);
    while (items.valid || expected_patches.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_patches.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
